// ===== rtl/i2cbs_pkg.sv =====
// shared types, codes and segment helpers for the i2c master bit sequencer
package i2cbs_pkg;

  // command codes
  localparam logic [2:0] CMD_START = 3'd0;
  localparam logic [2:0] CMD_STOP  = 3'd1;
  localparam logic [2:0] CMD_ACK   = 3'd2;
  localparam logic [2:0] CMD_NACK  = 3'd3;
  localparam logic [2:0] CMD_WAIT  = 3'd4;
  localparam logic [2:0] CMD_WRITE = 3'd5;
  localparam logic [2:0] CMD_READ  = 3'd6;

  // status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_BUSY     = 2'd1;
  localparam logic [1:0] ST_BUS_ERR  = 2'd2;
  localparam logic [1:0] ST_NO_ACK   = 2'd3;

  // sequence steps
  localparam logic [2:0] STEP_IDLE = 3'd0;
  localparam logic [2:0] STEP_1    = 3'd1;
  localparam logic [2:0] STEP_2    = 3'd2;
  localparam logic [2:0] STEP_3    = 3'd3;
  localparam logic [2:0] STEP_4    = 3'd4;

  localparam logic [3:0]  BITS_PER_BYTE = 4'd8;
  localparam logic [15:0] PHASE_RESET   = 16'd100;

  // one request entering the sequencer
  typedef struct packed {
    logic       cmd_valid;
    logic [2:0] command;
    logic [7:0] write_data;
    logic       sda_in;
  } item_t;

  // one result leaving the sequencer
  typedef struct packed {
    logic       scl_out;
    logic       sda_out;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_byte;
    logic [1:0] status;
  } res_t;

  // architectural state of the sequencer
  typedef struct packed {
    logic [15:0] tick_count;
    logic [2:0]  seq_step;
    logic [3:0]  bit_index;
    logic [7:0]  shift_reg;
    logic [2:0]  active_cmd;
    logic        scl_level;
    logic        sda_level;
    logic [1:0]  last_status;
    logic [7:0]  read_hold;
  } state_t;

  // drive changes on the first tick of a segment
  function automatic state_t enter_segment(state_t s);
    state_t n;
    n = s;
    unique case (s.active_cmd) inside
      CMD_START: begin
        if (s.seq_step == STEP_1) begin
          n.sda_level = 1'b1;
          n.scl_level = 1'b1;
        end else begin
          n.sda_level = 1'b0;
        end
      end
      CMD_STOP: begin
        if (s.seq_step == STEP_1)      n.scl_level = 1'b0;
        else if (s.seq_step == STEP_2) n.sda_level = 1'b0;
        else if (s.seq_step == STEP_3) n.scl_level = 1'b1;
        else                           n.sda_level = 1'b1;
      end
      CMD_ACK, CMD_NACK: begin
        if (s.seq_step == STEP_1)      n.scl_level = 1'b0;
        else if (s.seq_step == STEP_2) n.sda_level = (s.active_cmd == CMD_NACK);
        else if (s.seq_step == STEP_3) n.scl_level = 1'b1;
        else                           n.scl_level = 1'b0;
      end
      CMD_WAIT: begin
        if (s.seq_step == STEP_1)      n.scl_level = 1'b0;
        else if (s.seq_step == STEP_2) n.sda_level = 1'b1;
        else                           n.scl_level = 1'b1;
      end
      CMD_WRITE: begin
        if (s.seq_step == STEP_1) begin
          n.scl_level = 1'b0;
        end else begin
          n.sda_level = s.shift_reg[7];
          n.shift_reg = {s.shift_reg[6:0], 1'b0};
          n.scl_level = 1'b1;
        end
      end
      default: begin
        if (s.seq_step == STEP_1) begin
          n.shift_reg = {s.shift_reg[6:0], 1'b0};
          n.scl_level = 1'b0;
        end else begin
          n.scl_level = 1'b1;
        end
      end
    endcase
    n.tick_count = 16'd1;
    return n;
  endfunction

  // finish the running command with a status
  function automatic state_t complete_cmd(state_t s, logic [1:0] st);
    state_t n;
    n = s;
    n.last_status = st;
    n.seq_step    = STEP_IDLE;
    n.tick_count  = 16'd0;
    n.bit_index   = 4'd0;
    return n;
  endfunction

endpackage

// ===== rtl/i2c_master_bit_sequencer_top.sv =====
// Top level of the i2c master bit sequencer: stream ports, config register, pipeline
// Pipeline: a request is held in the input register, then its result in the result register.
// Throughput: one request per cycle while the result side accepts; the single tick of next-state logic sets the rate.
// Stalls on the output side hold the result register and back-pressure the input.
// Reset: lines released, sequencer idle, status ok, read byte 0, phase_ticks 100.
module i2c_master_bit_sequencer_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration write: phase_ticks
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_data_i,
  // request stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // write_data[7:0], sda_in[8], zero[15:9]
  input  logic [3:0]  s_axis_tuser,  // cmd_valid[0], command[3:1]
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata   // scl_out[0], sda_out[1], busy_res[2], done_res[3],
                                     // read_byte[11:4], status[13:12], zero[15:14]
);

  logic [15:0]      phase_ticks_q;
  logic             in_valid_q;
  i2cbs_pkg::item_t in_item_q;
  logic             out_valid_q;
  i2cbs_pkg::res_t  out_res_q;
  i2cbs_pkg::res_t  step_res;
  logic             advance;

  // config register, always writable
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_ticks_q <= i2cbs_pkg::PHASE_RESET;
    end else if (cfg_valid_i) begin
      phase_ticks_q <= cfg_data_i;
    end
  end

  // pipeline handshake
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_item_q.cmd_valid  <= s_axis_tuser[0];
      in_item_q.command    <= s_axis_tuser[3:1];
      in_item_q.write_data <= s_axis_tdata[7:0];
      in_item_q.sda_in     <= s_axis_tdata[8];
    end
  end

  i2cbs_core u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_en_i     (advance),
    .item_i        (in_item_q),
    .phase_ticks_i (phase_ticks_q),
    .res_o         (step_res)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_res_q <= step_res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {2'b00, out_res_q.status, out_res_q.read_byte,
                          out_res_q.done_res, out_res_q.busy_res,
                          out_res_q.sda_out, out_res_q.scl_out};

endmodule

// ===== rtl/i2cbs_core.sv =====
// sequencer state and one-tick next-state logic
module i2cbs_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               step_en_i,
  input  i2cbs_pkg::item_t   item_i,
  input  logic [15:0]        phase_ticks_i,
  output i2cbs_pkg::res_t    res_o
);

  i2cbs_pkg::state_t state_q, state_d;
  logic              done;
  logic [15:0]       limit;

  // zero delay behaves as one tick
  assign limit = (phase_ticks_i == 16'd0) ? 16'd1 : phase_ticks_i;

  // one timebase tick
  always_comb begin
    state_d = state_q;
    done    = 1'b0;
    if (state_q.seq_step == i2cbs_pkg::STEP_IDLE) begin
      if (item_i.cmd_valid && (item_i.command <= i2cbs_pkg::CMD_READ)) begin
        state_d.active_cmd = item_i.command;
        state_d.bit_index  = 4'd0;
        if (item_i.command == i2cbs_pkg::CMD_WRITE) state_d.shift_reg = item_i.write_data;
        if (item_i.command == i2cbs_pkg::CMD_READ) begin
          state_d.shift_reg = 8'd0;
          state_d.sda_level = 1'b1;
        end
        state_d.seq_step = i2cbs_pkg::STEP_1;
        state_d = i2cbs_pkg::enter_segment(state_d);
      end
    end else if (state_q.tick_count < limit) begin
      state_d.tick_count = state_q.tick_count + 16'd1;
    end else begin
      unique case (state_q.active_cmd) inside
        i2cbs_pkg::CMD_START: begin
          if (state_q.seq_step == i2cbs_pkg::STEP_1 && !item_i.sda_in) begin
            state_d = i2cbs_pkg::complete_cmd(state_q, i2cbs_pkg::ST_BUSY);
            done    = 1'b1;
          end else if (state_q.seq_step == i2cbs_pkg::STEP_2 && item_i.sda_in) begin
            state_d = i2cbs_pkg::complete_cmd(state_q, i2cbs_pkg::ST_BUS_ERR);
            done    = 1'b1;
          end else if (state_q.seq_step >= i2cbs_pkg::STEP_3) begin
            state_d = i2cbs_pkg::complete_cmd(state_q, i2cbs_pkg::ST_OK);
            done    = 1'b1;
          end else begin
            state_d.seq_step = state_q.seq_step + 3'd1;
            state_d = i2cbs_pkg::enter_segment(state_d);
          end
        end
        i2cbs_pkg::CMD_STOP, i2cbs_pkg::CMD_ACK, i2cbs_pkg::CMD_NACK: begin
          if (state_q.seq_step >= i2cbs_pkg::STEP_4) begin
            state_d = i2cbs_pkg::complete_cmd(state_q, i2cbs_pkg::ST_OK);
            done    = 1'b1;
          end else begin
            state_d.seq_step = state_q.seq_step + 3'd1;
            state_d = i2cbs_pkg::enter_segment(state_d);
          end
        end
        i2cbs_pkg::CMD_WAIT: begin
          if (state_q.seq_step >= i2cbs_pkg::STEP_3) begin
            state_d.scl_level = 1'b0;
            state_d = i2cbs_pkg::complete_cmd(state_d, item_i.sda_in ?
                                              i2cbs_pkg::ST_NO_ACK : i2cbs_pkg::ST_OK);
            done    = 1'b1;
          end else begin
            state_d.seq_step = state_q.seq_step + 3'd1;
            state_d = i2cbs_pkg::enter_segment(state_d);
          end
        end
        i2cbs_pkg::CMD_WRITE: begin
          if (state_q.seq_step == i2cbs_pkg::STEP_1) begin
            state_d.seq_step = i2cbs_pkg::STEP_2;
            state_d = i2cbs_pkg::enter_segment(state_d);
          end else begin
            state_d.bit_index = state_q.bit_index + 4'd1;
            if (state_d.bit_index >= i2cbs_pkg::BITS_PER_BYTE) begin
              state_d.scl_level = 1'b0;
              state_d = i2cbs_pkg::complete_cmd(state_d, i2cbs_pkg::ST_OK);
              done    = 1'b1;
            end else begin
              state_d.seq_step = i2cbs_pkg::STEP_1;
              state_d = i2cbs_pkg::enter_segment(state_d);
            end
          end
        end
        default: begin
          if (state_q.seq_step == i2cbs_pkg::STEP_1) begin
            state_d.seq_step = i2cbs_pkg::STEP_2;
            state_d = i2cbs_pkg::enter_segment(state_d);
          end else begin
            state_d.shift_reg = {state_q.shift_reg[7:1],
                                 state_q.shift_reg[0] | item_i.sda_in};
            state_d.bit_index = state_q.bit_index + 4'd1;
            if (state_d.bit_index >= i2cbs_pkg::BITS_PER_BYTE) begin
              state_d.scl_level = 1'b0;
              state_d.read_hold = state_d.shift_reg;
              state_d = i2cbs_pkg::complete_cmd(state_d, i2cbs_pkg::ST_OK);
              done    = 1'b1;
            end else begin
              state_d.seq_step = i2cbs_pkg::STEP_1;
              state_d = i2cbs_pkg::enter_segment(state_d);
            end
          end
        end
      endcase
    end
  end

  // result seen after this tick
  always_comb begin
    res_o.scl_out   = state_d.scl_level;
    res_o.sda_out   = state_d.sda_level;
    res_o.busy_res  = (state_d.seq_step != i2cbs_pkg::STEP_IDLE);
    res_o.done_res  = done;
    res_o.read_byte = state_d.read_hold;
    res_o.status    = state_d.last_status;
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.tick_count  <= 16'd0;
      state_q.seq_step    <= i2cbs_pkg::STEP_IDLE;
      state_q.bit_index   <= 4'd0;
      state_q.shift_reg   <= 8'd0;
      state_q.active_cmd  <= i2cbs_pkg::CMD_START;
      state_q.scl_level   <= 1'b1;
      state_q.sda_level   <= 1'b1;
      state_q.last_status <= i2cbs_pkg::ST_OK;
      state_q.read_hold   <= 8'd0;
    end else if (step_en_i) begin
      state_q <= state_d;
    end
  end

endmodule

// ===== tb/sv/testbench.sv =====
// self-checking stream testbench for the i2c master bit sequencer top level
module testbench;
  import i2cbs_pkg::*;

  localparam logic [2:0]  CMD_UNUSED   = 3'd7;
  localparam int unsigned RANDOM_TICKS = 160;
  localparam int unsigned STALL_LIMIT  = 2000;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned DRAIN_CYCLES = 8;

  // predicted sequencer state
  typedef struct packed {
    logic [15:0] ticks;
    logic [2:0]  step;
    logic [3:0]  nbit;
    logic [7:0]  shreg;
    logic [2:0]  op;
    logic        scl;
    logic        sda;
    logic [1:0]  status;
    logic [7:0]  rdbyte;
  } bus_state_t;

  // one directed command with its sda answers and optional typed outcome
  typedef struct {
    logic        set_phase;
    logic [15:0] phase;
    logic        valid;
    logic [2:0]  cmd;
    logic [7:0]  wdata;
    logic [7:0]  pattern;
    logic        noise;
    logic        typed;
    logic [7:0]  t_byte;
    logic [1:0]  t_status;
  } row_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        cfg_valid_i   = 1'b0;
  logic        cfg_ready_o;
  logic [15:0] cfg_data_i    = 16'd0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata  = 16'd0;
  logic [3:0]  s_axis_tuser  = 4'd0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;

  bus_state_t  bus;
  logic [15:0] phase_cfg;
  res_t        bus_result_q[$];
  row_t        directed_rows[$];
  int unsigned mismatch_cnt = 0;
  int unsigned burst_left   = 0;
  int unsigned tick_cnt     = 0;
  int unsigned quiet_cycles = 0;
  logic        hold_req     = 1'b0;
  logic        hold_done    = 1'b0;

  i2c_master_bit_sequencer_top uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // a zero delay behaves like a one-tick delay
  function automatic logic [31:0] delay_limit();
    return (phase_cfg == 16'd0) ? 32'd1 : {16'd0, phase_cfg};
  endfunction

  // line drives set on the first tick of a segment
  function automatic void enter_phase();
    case (bus.op)
      CMD_START: begin
        if (bus.step == STEP_1) bus.scl = 1'b1;
        bus.sda = (bus.step == STEP_1);
      end
      CMD_STOP: begin
        case (bus.step)
          STEP_1:  bus.scl = 1'b0;
          STEP_2:  bus.sda = 1'b0;
          STEP_3:  bus.scl = 1'b1;
          default: bus.sda = 1'b1;
        endcase
      end
      CMD_ACK, CMD_NACK: begin
        case (bus.step)
          STEP_1:  bus.scl = 1'b0;
          STEP_2:  bus.sda = (bus.op == CMD_NACK);
          STEP_3:  bus.scl = 1'b1;
          default: bus.scl = 1'b0;
        endcase
      end
      CMD_WAIT: begin
        case (bus.step)
          STEP_1:  bus.scl = 1'b0;
          STEP_2:  bus.sda = 1'b1;
          default: bus.scl = 1'b1;
        endcase
      end
      CMD_WRITE: begin
        if (bus.step == STEP_1) begin
          bus.scl = 1'b0;
        end else begin
          bus.sda   = bus.shreg[7];
          bus.shreg = {bus.shreg[6:0], 1'b0};
          bus.scl   = 1'b1;
        end
      end
      default: begin
        if (bus.step == STEP_1) begin
          bus.shreg = {bus.shreg[6:0], 1'b0};
          bus.scl   = 1'b0;
        end else begin
          bus.scl = 1'b1;
        end
      end
    endcase
    bus.ticks = 16'd1;
  endfunction

  function automatic void goto_step(logic [2:0] s);
    bus.step = s;
    enter_phase();
  endfunction

  function automatic logic finish_cmd(logic [1:0] st);
    bus.status = st;
    bus.step   = STEP_IDLE;
    bus.ticks  = 16'd0;
    bus.nbit   = 4'd0;
    return 1'b1;
  endfunction

  // tick after a delay ran out: sample sda, then advance or complete
  function automatic logic phase_elapsed(logic sda_in);
    logic fin;
    fin = 1'b0;
    case (bus.op)
      CMD_START: begin
        if (bus.step == STEP_1 && !sda_in)     fin = finish_cmd(ST_BUSY);
        else if (bus.step == STEP_2 && sda_in) fin = finish_cmd(ST_BUS_ERR);
        else if (bus.step >= STEP_3)           fin = finish_cmd(ST_OK);
        else                                   goto_step(bus.step + 3'd1);
      end
      CMD_STOP, CMD_ACK, CMD_NACK: begin
        if (bus.step >= STEP_4) fin = finish_cmd(ST_OK);
        else                    goto_step(bus.step + 3'd1);
      end
      CMD_WAIT: begin
        if (bus.step >= STEP_3) begin
          bus.scl = 1'b0;
          fin = finish_cmd(sda_in ? ST_NO_ACK : ST_OK);
        end else begin
          goto_step(bus.step + 3'd1);
        end
      end
      default: begin
        // write and read share the eight-bit loop
        if (bus.step == STEP_1) begin
          goto_step(STEP_2);
        end else begin
          if (bus.op == CMD_READ) bus.shreg[0] = bus.shreg[0] | sda_in;
          bus.nbit = bus.nbit + 4'd1;
          if (bus.nbit >= BITS_PER_BYTE) begin
            bus.scl = 1'b0;
            if (bus.op == CMD_READ) bus.rdbyte = bus.shreg;
            fin = finish_cmd(ST_OK);
          end else begin
            goto_step(STEP_1);
          end
        end
      end
    endcase
    return fin;
  endfunction

  // one timebase tick of the sequencer
  function automatic res_t advance_bus(item_t it);
    res_t r;
    logic fin;
    fin = 1'b0;
    if (bus.step == STEP_IDLE) begin
      // commands are taken only while idle, the unused code never
      if (it.cmd_valid && it.command != CMD_UNUSED) begin
        bus.op   = it.command;
        bus.nbit = 4'd0;
        if (it.command == CMD_WRITE) bus.shreg = it.write_data;
        if (it.command == CMD_READ) begin
          bus.shreg = 8'd0;
          bus.sda   = 1'b1;
        end
        goto_step(STEP_1);
      end
    end else if ({16'd0, bus.ticks} < delay_limit()) begin
      bus.ticks = bus.ticks + 16'd1;
    end else begin
      fin = phase_elapsed(it.sda_in);
    end
    r.scl_out   = bus.scl;
    r.sda_out   = bus.sda;
    r.busy_res  = (bus.step != STEP_IDLE);
    r.done_res  = fin;
    r.read_byte = bus.rdbyte;
    r.status    = bus.status;
    return r;
  endfunction

  // offer one request, in bursts with random gaps, and wait for it to be taken
  task automatic send_request(input item_t it);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 20);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {7'd0, it.sda_in, it.write_data};
    s_axis_tuser  <= {it.command, it.cmd_valid};
    do @(posedge clk_i); while (!s_axis_tready);
    burst_left--;
    tick_cnt++;
  endtask

  // issue a command and keep ticking until the sequencer is idle again
  task automatic run_command(input logic valid, input logic [2:0] cmd,
                             input logic [7:0] wdata, input logic [7:0] pattern,
                             input logic noise, input logic typed,
                             input logic [7:0] t_byte, input logic [1:0] t_status);
    item_t it;
    res_t  exp;
    logic  first;
    logic  sampling;
    first = 1'b1;
    do begin
      sampling = (bus.step != STEP_IDLE) && ({16'd0, bus.ticks} >= delay_limit());
      if (first) begin
        it.cmd_valid  = valid;
        it.command    = cmd;
        it.write_data = wdata;
      end else begin
        // commands offered while busy must be ignored
        it.cmd_valid  = noise && ($urandom_range(0, 2) == 0);
        it.command    = 3'($urandom_range(0, 7));
        it.write_data = 8'($urandom_range(0, 255));
      end
      // slave answers on sampling ticks, noise elsewhere
      if (!sampling)                                       it.sda_in = 1'($urandom_range(0, 1));
      else if (bus.op == CMD_READ)                         it.sda_in = pattern[3'd7 - bus.nbit[2:0]];
      else if (bus.op == CMD_START && bus.step == STEP_2) it.sda_in = pattern[6];
      else                                                 it.sda_in = pattern[7];
      send_request(it);
      exp = advance_bus(it);
      if (typed && bus.step == STEP_IDLE) begin
        exp.busy_res  = 1'b0;
        exp.done_res  = valid && (cmd != CMD_UNUSED);
        exp.read_byte = t_byte;
        exp.status    = t_status;
      end
      bus_result_q.push_back(exp);
      first = 1'b0;
    end while (bus.step != STEP_IDLE);
  endtask

  // change phase_ticks once all results are back and the pipeline is empty
  task automatic write_phase(input logic [15:0] value);
    s_axis_tvalid <= 1'b0;
    while (bus_result_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    phase_cfg = value;
  endtask

  task automatic add_row(input logic set_phase, input logic [15:0] phase, input logic valid,
                         input logic [2:0] cmd, input logic [7:0] wdata,
                         input logic [7:0] pattern, input logic noise, input logic typed,
                         input logic [7:0] t_byte, input logic [1:0] t_status);
    row_t r;
    r = '{set_phase, phase, valid, cmd, wdata, pattern, noise, typed, t_byte, t_status};
    directed_rows.push_back(r);
  endtask

  // stimulus: directed table, then random commands
  initial begin
    int unsigned cmds_since_cfg;
    int unsigned pick;
    logic [2:0]  op;
    logic [7:0]  pat;
    bus = '{ticks: 16'd0, step: STEP_IDLE, nbit: 4'd0, shreg: 8'd0, op: CMD_START,
            scl: 1'b1, sda: 1'b1, status: ST_OK, rdbyte: 8'd0};
    phase_cfg = PHASE_RESET;

    // reset state, unused code, one command at the reset delay
    add_row(1'b0, 16'd0, 1'b0, CMD_START, 8'h00, 8'h00, 1'b0, 1'b1, 8'h00, ST_OK);
    add_row(1'b0, 16'd0, 1'b1, CMD_UNUSED, 8'hFF, 8'h00, 1'b0, 1'b1, 8'h00, ST_OK);
    add_row(1'b0, 16'd0, 1'b1, CMD_START, 8'h00, 8'h00, 1'b1, 1'b1, 8'h00, ST_BUSY);
    // zero delay: start ok, bus busy, bus error
    add_row(1'b1, 16'd0, 1'b1, CMD_START, 8'h00, 8'h80, 1'b0, 1'b1, 8'h00, ST_OK);
    add_row(1'b0, 16'd0, 1'b1, CMD_START, 8'h00, 8'h00, 1'b1, 1'b1, 8'h00, ST_BUSY);
    add_row(1'b0, 16'd0, 1'b1, CMD_START, 8'h00, 8'hC0, 1'b0, 1'b1, 8'h00, ST_BUS_ERR);
    // byte writes at the data extremes and a mixed pattern
    add_row(1'b0, 16'd0, 1'b1, CMD_WRITE, 8'hFF, 8'h00, 1'b1, 1'b0, 8'h00, ST_OK);
    add_row(1'b0, 16'd0, 1'b1, CMD_WRITE, 8'h00, 8'hFF, 1'b0, 1'b0, 8'h00, ST_OK);
    add_row(1'b0, 16'd0, 1'b1, CMD_WRITE, 8'hA5, 8'h5A, 1'b1, 1'b0, 8'h00, ST_OK);
    // acknowledge polling, a stop, reads, then ack and nack
    add_row(1'b0, 16'd0, 1'b1, CMD_WAIT, 8'h00, 8'h00, 1'b0, 1'b1, 8'h00, ST_OK);
    add_row(1'b0, 16'd0, 1'b1, CMD_WAIT, 8'h00, 8'h80, 1'b1, 1'b1, 8'h00, ST_NO_ACK);
    add_row(1'b0, 16'd0, 1'b1, CMD_STOP, 8'h00, 8'h00, 1'b0, 1'b0, 8'h00, ST_OK);
    add_row(1'b0, 16'd0, 1'b1, CMD_READ, 8'h00, 8'hFF, 1'b0, 1'b1, 8'hFF, ST_OK);
    add_row(1'b0, 16'd0, 1'b1, CMD_READ, 8'h00, 8'h00, 1'b1, 1'b1, 8'h00, ST_OK);
    add_row(1'b0, 16'd0, 1'b1, CMD_READ, 8'h00, 8'h5A, 1'b0, 1'b1, 8'h5A, ST_OK);
    add_row(1'b0, 16'd0, 1'b1, CMD_ACK, 8'h00, 8'h00, 1'b0, 1'b0, 8'h00, ST_OK);
    add_row(1'b0, 16'd0, 1'b1, CMD_NACK, 8'h00, 8'h00, 1'b1, 1'b0, 8'h00, ST_OK);
    // other short delays
    add_row(1'b1, 16'd1, 1'b1, CMD_START, 8'h00, 8'h80, 1'b1, 1'b0, 8'h00, ST_OK);
    add_row(1'b1, 16'd3, 1'b1, CMD_READ, 8'h00, 8'h96, 1'b1, 1'b1, 8'h96, ST_OK);
    add_row(1'b1, 16'd20, 1'b1, CMD_START, 8'h00, 8'h00, 1'b0, 1'b1, 8'h96, ST_BUSY);
    add_row(1'b1, 16'd2, 1'b1, CMD_STOP, 8'h00, 8'h00, 1'b1, 1'b0, 8'h00, ST_OK);
    add_row(1'b0, 16'd0, 1'b1, CMD_UNUSED, 8'h00, 8'h00, 1'b0, 1'b1, 8'h96, ST_OK);

    wait (rst_ni);
    @(posedge clk_i);
    foreach (directed_rows[i]) begin
      if (directed_rows[i].set_phase) write_phase(directed_rows[i].phase);
      run_command(directed_rows[i].valid, directed_rows[i].cmd, directed_rows[i].wdata,
                  directed_rows[i].pattern, directed_rows[i].noise, directed_rows[i].typed,
                  directed_rows[i].t_byte, directed_rows[i].t_status);
    end

    // random commands with short delays so that sequences complete often
    tick_cnt = 0;
    cmds_since_cfg = 0;
    while (tick_cnt < RANDOM_TICKS) begin
      if (cmds_since_cfg == 4) begin
        write_phase(16'($urandom_range(0, 5)));
        cmds_since_cfg = 0;
      end
      if (tick_cnt > RANDOM_TICKS / 3) hold_req = 1'b1;
      repeat ($urandom_range(0, 2))
        run_command(1'b0, 3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)), 8'h00,
                    1'b0, 1'b0, 8'h00, ST_OK);
      pick = $urandom_range(0, 15);
      op   = (pick < 14) ? 3'(pick % 7) : CMD_UNUSED;
      pat  = 8'($urandom_range(0, 255));
      // mostly a free bus so that starts run to the end
      if (op == CMD_START && $urandom_range(0, 4) != 0) pat = 8'h80;
      run_command(1'b1, op, 8'($urandom_range(0, 255)), pat, 1'($urandom_range(0, 1)),
                  1'b0, 8'h00, ST_OK);
      cmds_since_cfg++;
    end

    s_axis_tvalid <= 1'b0;
    while (bus_result_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("i2c_master_bit_sequencer_top verification clean");
    end else begin
      $display("i2c_master_bit_sequencer_top verification failed");
    end
    $finish;
  end

  // result side: stall pattern that changes mode, plus one long hold-off
  initial begin
    int unsigned rx_cnt;
    int unsigned rx_mode;
    rx_cnt  = 0;
    rx_mode = 0;
    forever begin
      @(posedge clk_i);
      if (hold_req && !hold_done) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_done = 1'b1;
      end
      rx_cnt++;
      if (rx_cnt % 64 == 0) rx_mode = $urandom_range(0, 3);
      case (rx_mode)
        0:       m_axis_tready <= 1'b1;
        1:       m_axis_tready <= (rx_cnt % 4 != 3);
        2:       m_axis_tready <= 1'($urandom_range(0, 1));
        default: m_axis_tready <= (rx_cnt % 8 == 0);
      endcase
    end
  end

  // compare each result with the oldest prediction
  always @(posedge clk_i) begin
    res_t got;
    res_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.scl_out   = m_axis_tdata[0];
      got.sda_out   = m_axis_tdata[1];
      got.busy_res  = m_axis_tdata[2];
      got.done_res  = m_axis_tdata[3];
      got.read_byte = m_axis_tdata[11:4];
      got.status    = m_axis_tdata[13:12];
      if (bus_result_q.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10) $display("result %h arrived with nothing pending", m_axis_tdata);
      end else begin
        want = bus_result_q.pop_front();
        if (got != want) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("mismatch: expected scl %0b sda %0b busy %0b done %0b byte %h status %0d, %s",
                     want.scl_out, want.sda_out, want.busy_res, want.done_res,
                     want.read_byte, want.status,
                     $sformatf("got scl %0b sda %0b busy %0b done %0b byte %h status %0d",
                               got.scl_out, got.sda_out, got.busy_res, got.done_res,
                               got.read_byte, got.status));
        end
      end
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid_i && cfg_ready_o)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("i2c_master_bit_sequencer_top verification failed");
        $finish;
      end
    end
  end

endmodule
